### src/value_searchable_stack_core_macros.svh
// Assertion macros used by the top level of the value searchable stack.
`ifndef VALUE_SEARCHABLE_STACK_CORE_MACROS_SVH
`define VALUE_SEARCHABLE_STACK_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock, idle while in reset.
`define VSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define VSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VSS_ASSERT_IMP(lbl, ante, cons, msg)
`define VSS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### src/vss_pkg.sv
// Types and codes of the value searchable stack.
`timescale 1ns / 1ps
package vss_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DUMP
    } t_state;

    localparam logic [2:0] MODE_PUSH   = 3'd0;
    localparam logic [2:0] MODE_DUMP   = 3'd1;
    localparam logic [2:0] MODE_SEARCH = 3'd2;
    localparam logic [2:0] MODE_MODIFY = 3'd3;
    localparam logic [2:0] MODE_DELETE = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    // Most entries that one dump lists.
    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] entry_data;
        logic               last;
    } t_result;

endpackage

### src/vss_ram.sv
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module vss_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic signed [31:0]  i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output logic signed [31:0]  o_rd_data
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/vss_rq.sv
// Two-entry result queue in front of the output channel.
`timescale 1ns / 1ps
module vss_rq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_enq,
    input  vss_pkg::t_result i_item,
    input  logic             i_stall,
    output logic             o_valid,
    output vss_pkg::t_result o_item,
    output logic [1:0]       o_cnt
);

    vss_pkg::t_result r_buf [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             n_wptr;
    logic             n_rptr;
    logic [1:0]       n_cnt;
    logic             pop;

    assign pop = (r_cnt != 2'd0) && !i_stall;

    always_comb begin
        n_wptr = r_wptr ^ i_enq;
        n_rptr = r_rptr ^ pop;
        n_cnt  = r_cnt + 2'(i_enq) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_buf[r_wptr] <= i_item;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_buf[r_rptr];
    assign o_cnt   = r_cnt;

endmodule

### src/value_searchable_stack_core.sv
// Top level of the value searchable stack: request sequencer around the entry memory.
// Usage:
//   Input channel (i_valid / o_stall) carries one request item: i_mode selects push,
//   dump, search, modify-first-match or delete-first-match; i_value is the pushed data
//   or the search key; i_new_value is the replacement for a modify.
//   Output channel (o_valid / i_stall) carries result items: o_status, o_entry_data and
//   o_last, which marks the final result of a request. A dump gives one item per entry
//   (topmost first, at most 16); every other request gives one item; unused modes none.
// Timing:
//   One request is worked on at a time; o_stall is high while a request is in progress
//   or while the two-entry result queue is full. Push and every request on an empty
//   stack finish in the accept cycle. Search and modify walk the memory's single read
//   port one entry per cycle from the top; delete walks the same way, then shifts each
//   entry above the match down by one place. A dump streams one entry per cycle while
//   the receiver takes them: it accepts the request, reads the entries in turn and ends
//   with the data of the last entry read.
// Reset and stall:
//   Synchronous reset empties the stack and the result queue; entry contents are left
//   as they are and are never read before a push writes them. When the receiver
//   stalls, the pending result holds and a dump pauses its memory reads.
`timescale 1ns / 1ps
`include "value_searchable_stack_core_macros.svh"
module value_searchable_stack_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_new_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_entry_data,
    output logic               o_last
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    vss_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_next, n_next;
    logic               r_more, n_more;
    logic [CW-1:0]      r_left, n_left;
    logic [AW-1:0]      r_j, n_j;
    logic [2:0]         r_mode, n_mode;
    logic signed [31:0] r_key, n_key;
    logic signed [31:0] r_repl, n_repl;

    // Read tracking: what the memory returns this cycle.
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;
    logic               r_rd_last;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               rd_last;
    logic signed [31:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    logic               enq;
    vss_pkg::t_result   enq_item;
    vss_pkg::t_result   q_item;
    logic [1:0]         q_cnt;
    logic               pop;

    logic               in_acc;
    logic               empty;
    logic               full;
    logic               hit;
    logic               top_hit;
    logic               shift_done;
    logic               dump_credit;
    logic               push_ok;
    logic               dump_data;

    vss_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    vss_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .i_item  (enq_item),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_item  (q_item),
        .o_cnt   (q_cnt)
    );

    assign o_status     = q_item.status;
    assign o_entry_data = q_item.entry_data;
    assign o_last       = q_item.last;

    // Take a request only when idle and the queue has room for its first result.
    assign o_stall = (r_state != vss_pkg::ST_IDLE) || (q_cnt == 2'd2);
    assign in_acc  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    assign empty      = (r_count == '0);
    assign full       = (r_count == CW'(STACK_DEPTH));
    assign hit        = r_rd_vld && (rd_data == r_key);
    assign top_hit    = (CW'(r_rd_idx) == r_count - CW'(1));
    assign shift_done = ((CW'(r_j) + CW'(2)) == r_count);

    // A dump read may issue only if its data is sure to find a queue slot next cycle.
    assign dump_credit = (3'(q_cnt) + 3'(r_rd_vld)) <= (3'd1 + 3'(pop));

    assign push_ok   = in_acc && (i_mode == vss_pkg::MODE_PUSH) && !full;
    assign dump_data = r_rd_vld && (r_state == vss_pkg::ST_DUMP);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            vss_pkg::ST_IDLE: begin
                if (in_acc && !empty) begin
                    if (i_mode == vss_pkg::MODE_DUMP) begin
                        n_state = vss_pkg::ST_DUMP;
                    end else if (i_mode inside {vss_pkg::MODE_SEARCH, vss_pkg::MODE_MODIFY,
                                                vss_pkg::MODE_DELETE}) begin
                        n_state = vss_pkg::ST_SCAN;
                    end
                end
            end
            vss_pkg::ST_SCAN: begin
                if (hit) begin
                    if ((r_mode == vss_pkg::MODE_DELETE) && !top_hit) begin
                        n_state = vss_pkg::ST_SHIFT;
                    end else begin
                        n_state = vss_pkg::ST_IDLE;
                    end
                end else if (r_rd_vld && (r_rd_idx == '0)) begin
                    n_state = vss_pkg::ST_IDLE;
                end
            end
            vss_pkg::ST_SHIFT: begin
                if (shift_done) begin
                    n_state = vss_pkg::ST_IDLE;
                end
            end
            vss_pkg::ST_DUMP: begin
                if (r_rd_vld && r_rd_last) begin
                    n_state = vss_pkg::ST_IDLE;
                end
            end
            default: n_state = vss_pkg::ST_IDLE;
        endcase
    end

    // Memory accesses, results and datapath registers.
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        rd_last  = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        enq      = 1'b0;
        enq_item = '{status: vss_pkg::STAT_OK, entry_data: 32'sd0, last: 1'b1};
        n_count  = r_count;
        n_next   = r_next;
        n_more   = r_more;
        n_left   = r_left;
        n_j      = r_j;
        n_mode   = r_mode;
        n_key    = r_key;
        n_repl   = r_repl;
        case (r_state)
            vss_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_mode = i_mode;
                    n_key  = i_value;
                    n_repl = i_new_value;
                    case (i_mode)
                        vss_pkg::MODE_PUSH: begin
                            enq = 1'b1;
                            if (full) begin
                                enq_item.status = vss_pkg::STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(r_count);
                                wr_data = i_value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        vss_pkg::MODE_DUMP: begin
                            if (empty) begin
                                enq             = 1'b1;
                                enq_item.status = vss_pkg::STAT_EMPTY;
                            end else begin
                                n_next = AW'(r_count - CW'(1));
                                n_left = (32'(r_count) > vss_pkg::MAX_RESULTS) ?
                                         CW'(vss_pkg::MAX_RESULTS) : r_count;
                            end
                        end
                        vss_pkg::MODE_SEARCH, vss_pkg::MODE_MODIFY,
                        vss_pkg::MODE_DELETE: begin
                            if (empty) begin
                                enq             = 1'b1;
                                enq_item.status = vss_pkg::STAT_EMPTY;
                            end else begin
                                // Start the walk at the top entry.
                                rd_en   = 1'b1;
                                rd_addr = AW'(r_count - CW'(1));
                                n_next  = AW'(r_count - CW'(2));
                                n_more  = (r_count >= CW'(2));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            vss_pkg::ST_SCAN: begin
                if (hit) begin
                    case (r_mode)
                        vss_pkg::MODE_MODIFY: begin
                            wr_en   = 1'b1;
                            wr_addr = r_rd_idx;
                            wr_data = r_repl;
                            enq     = 1'b1;
                        end
                        vss_pkg::MODE_DELETE: begin
                            if (top_hit) begin
                                n_count = r_count - CW'(1);
                                enq     = 1'b1;
                            end else begin
                                // Fetch the entry above the match to move it down.
                                rd_en   = 1'b1;
                                rd_addr = AW'(CW'(r_rd_idx) + CW'(1));
                                n_j     = r_rd_idx;
                            end
                        end
                        default: enq = 1'b1;
                    endcase
                end else if (r_rd_vld) begin
                    if (r_rd_idx == '0) begin
                        enq             = 1'b1;
                        enq_item.status = vss_pkg::STAT_NOT_FOUND;
                    end else if (r_more) begin
                        rd_en   = 1'b1;
                        rd_addr = r_next;
                        n_next  = r_next - AW'(1);
                        n_more  = (r_next != '0);
                    end
                end
            end
            vss_pkg::ST_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = rd_data;
                if (shift_done) begin
                    n_count = r_count - CW'(1);
                    enq     = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(CW'(r_j) + CW'(2));
                    n_j     = AW'(CW'(r_j) + CW'(1));
                end
            end
            vss_pkg::ST_DUMP: begin
                if (r_rd_vld) begin
                    enq                 = 1'b1;
                    enq_item.entry_data = rd_data;
                    enq_item.last       = r_rd_last;
                end
                if ((r_left != '0) && dump_credit) begin
                    rd_en   = 1'b1;
                    rd_addr = r_next;
                    rd_last = (r_left == CW'(1));
                    n_next  = r_next - AW'(1);
                    n_left  = r_left - CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vss_pkg::ST_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_more   <= 1'b0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= rd_en;
            r_more   <= n_more;
            r_left   <= n_left;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        r_next <= n_next;
        r_j    <= n_j;
        r_mode <= n_mode;
        r_key  <= n_key;
        r_repl <= n_repl;
        if (rd_en) begin
            r_rd_idx  <= rd_addr;
            r_rd_last <= rd_last;
        end
    end

    // The walk keeps one read in flight every cycle it is in the scan state.
    `VSS_ASSERT_IMP(a_scan_read, r_state == vss_pkg::ST_SCAN, r_rd_vld, "scan without read data")
    // The fill count never passes the depth.
    `VSS_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(STACK_DEPTH), "entry count over depth")
    // An accepted push to a stack with room grows it by one.
    `VSS_ASSERT_NXT(a_push_grow, push_ok, r_count == $past(r_count) + CW'(1), "push lost")
    // A dump read never lands in a full queue.
    `VSS_ASSERT_IMP(a_dump_room, dump_data, (q_cnt != 2'd2) || pop, "dump data with no room")

endmodule

### tb/tb_top.sv
// Self-checking testbench for value_searchable_stack_core: directed cases, then random traffic.
`timescale 1ns / 1ps
module tb_top;

    // Depth of the instance; the shadow stack below tracks the same bound.
    localparam int STACK_DEPTH = 16;

    // Codes that the block ignores: no result comes back for them.
    localparam logic [2:0] MODE_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] MODE_RESERVED_LAST  = 3'd7;

    localparam int REPORT_LIMIT = 10;
    // Timeout bound for the whole run, well above what a legal run needs.
    localparam int LIMIT_CYCLES = 400000;
    // Longest request is a delete of the bottom entry.
    localparam int TAIL_CYCLES = 4 * STACK_DEPTH + 16;
    localparam int PHASE_ITEMS = 83;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [2:0]         i_mode      = vss_pkg::MODE_PUSH;
    logic signed [31:0] i_value     = '0;
    logic signed [31:0] i_new_value = '0;
    logic               i_stall     = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_entry_data;
    logic               o_last;

    // Shadow copy of the stack: entry 0 is the bottom, shadow_count-1 the top.
    logic signed [31:0] shadow_entries [STACK_DEPTH];
    int                 shadow_count = 0;

    // Results that accepted requests still owe, oldest first.
    vss_pkg::t_result   stack_results_due [$];
    vss_pkg::t_result   head_result;

    int                 idle_pct       = 0;
    int                 stall_pct      = 0;
    int                 mismatch_count = 0;
    int                 results_seen   = 0;
    int                 cycle_count    = 0;

    value_searchable_stack_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_new_value  (i_new_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_entry_data (o_entry_data),
        .o_last       (o_last)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void queue_result(logic [1:0] status, logic signed [31:0] data,
                                         logic last);
        vss_pkg::t_result r;
        r.status     = status;
        r.entry_data = data;
        r.last       = last;
        stack_results_due.push_back(r);
    endfunction

    // Apply one accepted request to the shadow stack and queue what it owes.
    function automatic void apply_stack_request(logic [2:0] mode, logic signed [31:0] key,
                                                logic signed [31:0] repl);
        int pos;
        int i;
        int n;
        pos = -1;
        case (mode)
            vss_pkg::MODE_PUSH: begin
                if (shadow_count >= STACK_DEPTH) begin
                    queue_result(vss_pkg::STAT_FULL, '0, 1'b1);
                end else begin
                    shadow_entries[shadow_count] = key;
                    shadow_count++;
                    queue_result(vss_pkg::STAT_OK, '0, 1'b1);
                end
            end
            vss_pkg::MODE_DUMP: begin
                if (shadow_count == 0) begin
                    queue_result(vss_pkg::STAT_EMPTY, '0, 1'b1);
                end else begin
                    // List topmost first; only the top MAX_RESULTS entries show.
                    n = (shadow_count > vss_pkg::MAX_RESULTS) ? vss_pkg::MAX_RESULTS
                                                              : shadow_count;
                    for (i = 0; i < n; i++) begin
                        queue_result(vss_pkg::STAT_OK, shadow_entries[shadow_count - 1 - i],
                                     (i == n - 1));
                    end
                end
            end
            vss_pkg::MODE_SEARCH, vss_pkg::MODE_MODIFY, vss_pkg::MODE_DELETE: begin
                if (shadow_count == 0) begin
                    queue_result(vss_pkg::STAT_EMPTY, '0, 1'b1);
                end else begin
                    // Walk from the top; stop at the first match.
                    for (i = shadow_count - 1; i >= 0 && pos < 0; i--) begin
                        if (shadow_entries[i] == key) begin
                            pos = i;
                        end
                    end
                    if (pos < 0) begin
                        queue_result(vss_pkg::STAT_NOT_FOUND, '0, 1'b1);
                    end else begin
                        if (mode == vss_pkg::MODE_MODIFY) begin
                            shadow_entries[pos] = repl;
                        end else if (mode == vss_pkg::MODE_DELETE) begin
                            // Close the gap and keep the order of the rest.
                            for (i = pos; i < shadow_count - 1; i++) begin
                                shadow_entries[i] = shadow_entries[i + 1];
                            end
                            shadow_count--;
                        end
                        queue_result(vss_pkg::STAT_OK, '0, 1'b1);
                    end
                end
            end
            default: begin
                // Reserved codes: swallowed without a result.
            end
        endcase
    endfunction

    // Mostly a small pool with the extremes, so duplicates and matches are common.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            4, 5, 6: return $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one item and hold it until accepted; valid stays high afterwards
    // so back-to-back items need no extra assignment in the same step.
    task automatic send_request(logic [2:0] mode, logic signed [31:0] key,
                                logic signed [31:0] repl);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_value     <= key;
        i_new_value <= repl;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        apply_stack_request(mode, key, repl);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (stack_results_due.size() != 0);
    endtask

    // Dump, search, modify and delete on an empty stack each report empty.
    task automatic test_empty_stack();
        send_request(vss_pkg::MODE_DUMP, '0, '0);
        send_request(vss_pkg::MODE_SEARCH, 32'sh7FFF_FFFF, '0);
        send_request(vss_pkg::MODE_MODIFY, 32'sh8000_0000, -32'sd1);
        send_request(vss_pkg::MODE_DELETE, -32'sd1, '0);
        drain_results();
    endtask

    // Reserved codes are swallowed; nothing must come back.
    task automatic test_reserved_modes();
        send_request(MODE_RESERVED_FIRST, $urandom, $urandom);
        send_request(MODE_RESERVED_LAST, $urandom, $urandom);
        drain_results();
    endtask

    // Fill with extremes and duplicates, then push once more into a full stack.
    task automatic test_fill_to_full();
        int i;
        logic signed [31:0] v;
        for (i = 0; i <= STACK_DEPTH; i++) begin
            case (i)
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7FFF_FFFF;
                2:       v = '0;
                3:       v = -32'sd1;
                default: v = i % 3;
            endcase
            send_request(vss_pkg::MODE_PUSH, v, '0);
        end
        drain_results();
    endtask

    // On the full stack: dump it all, miss a key, modify a duplicate, delete the bottom, dump again.
    task automatic test_edit_full_stack();
        send_request(vss_pkg::MODE_DUMP, '0, '0);
        send_request(vss_pkg::MODE_SEARCH, 32'sh5A5A_5A5A, '0);
        send_request(vss_pkg::MODE_MODIFY, 32'sd1, 32'shA5A5_A5A5);
        send_request(vss_pkg::MODE_DELETE, 32'sh8000_0000, '0);
        send_request(vss_pkg::MODE_DUMP, '0, '0);
        drain_results();
    endtask

    // Random traffic biased toward hits: most non-push keys are taken from the live stack.
    task automatic test_random_traffic(int idle, int stall);
        int                 k;
        int                 r;
        int                 push_weight;
        logic [2:0]         mode;
        logic signed [31:0] key;
        idle_pct  = idle;
        stall_pct = stall;
        for (k = 0; k < PHASE_ITEMS; k++) begin
            // Push harder while shallow, so the stack climbs to full and back.
            push_weight = (shadow_count < STACK_DEPTH / 2) ? 50 : 25;
            r = $urandom_range(99);
            if (r < push_weight) begin
                mode = vss_pkg::MODE_PUSH;
            end else if (r < push_weight + 8) begin
                mode = vss_pkg::MODE_DUMP;
            end else if (r < push_weight + 23) begin
                mode = vss_pkg::MODE_SEARCH;
            end else if (r < push_weight + 38) begin
                mode = vss_pkg::MODE_MODIFY;
            end else if (r < 96) begin
                mode = vss_pkg::MODE_DELETE;
            end else begin
                mode = 3'($urandom_range(MODE_RESERVED_LAST, MODE_RESERVED_FIRST));
            end
            if (mode != vss_pkg::MODE_PUSH && shadow_count > 0 && $urandom_range(99) < 70) begin
                key = shadow_entries[$urandom_range(shadow_count - 1)];
            end else begin
                key = pick_value();
            end
            send_request(mode, key, pick_value());
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------

    // Compare each taken result with the oldest one owed; then draw the next stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (stack_results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("result %0d unexpected: status=%0d data=%0d last=%0d",
                                 results_seen, o_status, o_entry_data, o_last);
                    end
                end else begin
                    head_result = stack_results_due.pop_front();
                    if (o_status !== head_result.status
                            || o_entry_data !== head_result.entry_data
                            || o_last !== head_result.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("result %0d: expected status=%0d data=%0d last=%0d,",
                                     results_seen, head_result.status,
                                     head_result.entry_data, head_result.last,
                                     " got status=%0d data=%0d last=%0d",
                                     o_status, o_entry_data, o_last);
                        end
                    end
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Stop a hung run.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("value_searchable_stack_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stack();
        test_reserved_modes();
        test_fill_to_full();
        test_edit_full_stack();

        // Idling phases: none, sender only, receiver only, both.
        test_random_traffic(0, 0);
        test_random_traffic(52, 0);
        test_random_traffic(0, 52);
        test_random_traffic(20, 20);

        // Let any late or extra result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && stack_results_due.size() == 0) begin
            $display("value_searchable_stack_core: match");
        end else begin
            $display("value_searchable_stack_core: mismatch");
        end
        $finish;
    end

endmodule
